// ===== hdl/clef_pkg.sv =====
// clef_pkg: sizes, constants and the per-column entry type for the column line edge finder
// no dependencies; imported by column_line_edge_finder
`default_nettype none

package clef_pkg;

    localparam int ROWS            = 80;
    localparam int COLUMNS         = 60;
    localparam int NEAR_EDGE_VALUE = 75;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 7;
    localparam int HIST_W = 3;
    localparam int SUM_W  = 13;
    localparam int CNT_W  = 7;

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(128);

    // one word of the column memory
    typedef struct packed {
        logic [ROW_W-1:0]  line;
        logic              found;
        logic [HIST_W-1:0] hist;
    } t_entry;

endpackage

`default_nettype wire

// ===== hdl/column_line_edge_finder.sv =====
// column_line_edge_finder: per-column dark edge search over a raster pixel stream
// depends on clef_pkg (sizes, constants, t_entry)
`default_nettype none

// Pixels stream in raster order, one per clock while the frame is running. Each column's
// state (three rows of dark history, found flag, line position) lives in one synchronous
// memory of COLUMNS words; a two-stage read-modify-write handles a pixel per cycle, with the
// write data forwarded when the next pixel hits the same word. A pixel with frame_start high
// drops any frame in progress. After the last pixel of a frame the input stalls while the
// block sweeps the columns: a drain state retires the last write, a read and an emit state
// per column read the memory and present its result (the emit state waits while the output
// is held off), a bit-serial divide forms the average, then the average item goes out.
// Per-column valid flops reset all columns at once, so no clearing pass is needed.
module column_line_edge_finder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [clef_pkg::PIX_W-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [clef_pkg::PIX_W-1:0]   i_pixel,
    input  wire logic                         i_frame_start,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [clef_pkg::COL_W-1:0]        o_column,
    output logic [clef_pkg::ROW_W-1:0]        o_line_row,
    output logic                              o_found,
    output logic [clef_pkg::ROW_W-1:0]        o_average,
    output logic                              o_last
);
    import clef_pkg::*;

    typedef enum logic [2:0] {ST_RUN, ST_DRAIN, ST_RD, ST_EMIT, ST_DIV, ST_AVG} t_state;

    t_state             r_state;
    logic [PIX_W-1:0]   r_threshold;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COLUMNS-1:0] r_valid;

    t_entry             r_mem [COLUMNS];
    t_entry             r_rdata;

    // write stage
    logic               r_s1_act;
    logic [COL_W-1:0]   r_s1_col;
    logic               r_s1_dark;
    logic               r_s1_row_ok;
    logic [ROW_W-1:0]   r_s1_line;
    logic               r_s1_vld;
    logic               r_s1_hit;
    t_entry             r_s1_fwd;

    // frame end sweep and divide
    logic [COL_W-1:0]     r_sw_col;
    logic                 r_sw_vld;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_step;

    // output register
    logic               r_out_valid;
    logic [COL_W-1:0]   r_column;
    logic [ROW_W-1:0]   r_line_row;
    logic               r_found;
    logic [ROW_W-1:0]   r_average;
    logic               r_last;

    logic               in_accept;
    logic [COL_W-1:0]   c_eff;
    logic [ROW_W-1:0]   r_eff;
    logic               last_col;
    logic               frame_end;
    logic               rd_en;
    logic [COL_W-1:0]   rd_addr;
    t_entry             cur;
    t_entry             wr;
    logic               near_hit;
    logic               edge_hit;
    logic               out_free;
    logic               sw_found;
    logic [ROW_W-1:0]   sw_value;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W:0]     div_t;
    logic [CNT_W:0]     div_sub;
    logic               div_ge;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_RUN);
    assign in_accept   = i_in_valid && o_in_ready;

    assign c_eff     = i_frame_start ? '0 : r_col;
    assign r_eff     = i_frame_start ? '0 : r_row;
    assign last_col  = (c_eff == COL_W'(COLUMNS - 1));
    assign frame_end = last_col && (r_eff == ROW_W'(ROWS - 1));

    assign rd_en   = in_accept || (r_state == ST_RD);
    assign rd_addr = (r_state == ST_RD) ? r_sw_col : c_eff;

    // modify step of the column word
    always_comb begin
        cur = r_s1_hit ? r_s1_fwd : (r_s1_vld ? r_rdata : '0);
        near_hit = r_s1_row_ok && r_s1_dark && cur.hist[0];
        edge_hit = r_s1_row_ok && !r_s1_dark && !cur.hist[0] && cur.hist[1] && cur.hist[2];
        wr.hist  = {cur.hist[HIST_W-2:0], r_s1_dark};
        wr.found = cur.found || near_hit || edge_hit;
        if (near_hit) begin
            wr.line = ROW_W'(NEAR_EDGE_VALUE);
        end else if (edge_hit) begin
            wr.line = r_s1_line;
        end else begin
            wr.line = cur.line;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign sw_found = r_sw_vld && r_rdata.found;
    assign sw_value = sw_found ? r_rdata.line : '0;
    assign sum_next = r_sum + SUM_W'(sw_value);
    assign cnt_next = r_cnt + CNT_W'(sw_found);

    // one quotient bit a cycle
    assign div_t   = {r_rem, r_quo[SUM_W-1]};
    assign div_ge  = (div_t >= {1'b0, r_cnt});
    assign div_sub = div_t - {1'b0, r_cnt};

    always_ff @(posedge i_clk) begin
        if (r_s1_act) begin
            r_mem[r_s1_col] <= wr;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_threshold <= THRESHOLD_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_valid     <= '0;
            r_s1_act    <= 1'b0;
            r_s1_col    <= '0;
            r_s1_dark   <= 1'b0;
            r_s1_row_ok <= 1'b0;
            r_s1_line   <= '0;
            r_s1_vld    <= 1'b0;
            r_s1_hit    <= 1'b0;
            r_s1_fwd    <= '0;
            r_sw_col    <= '0;
            r_sw_vld    <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= CNT_W'(1);
            r_quo       <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_column    <= '0;
            r_line_row  <= '0;
            r_found     <= 1'b0;
            r_average   <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_threshold <= i_cfg_data;
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // a frame start clear wins over the previous pixel's write setting its bit
            if (in_accept && i_frame_start) begin
                r_valid <= '0;
            end else if (r_s1_act) begin
                r_valid[r_s1_col] <= 1'b1;
            end

            r_s1_act <= in_accept;
            if (in_accept) begin
                r_s1_col    <= c_eff;
                r_s1_dark   <= (i_pixel < r_threshold);
                r_s1_row_ok <= (r_eff >= ROW_W'(3));
                r_s1_line   <= r_eff - ROW_W'(2);
                r_s1_vld    <= !i_frame_start && r_valid[c_eff];
                // the word being written now is the one read now
                r_s1_hit    <= r_s1_act && (r_s1_col == c_eff) && !i_frame_start;
                r_s1_fwd    <= wr;
                if (frame_end) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_state <= ST_DRAIN;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= r_eff + ROW_W'(1);
                end else begin
                    r_col <= c_eff + COL_W'(1);
                    r_row <= r_eff;
                end
            end

            case (r_state)
                ST_RUN: begin
                end
                ST_DRAIN: begin
                    r_sw_col <= '0;
                    r_sum    <= '0;
                    r_cnt    <= CNT_W'(1);
                    r_state  <= ST_RD;
                end
                ST_RD: begin
                    r_sw_vld <= r_valid[r_sw_col];
                    r_state  <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_column    <= r_sw_col;
                        r_line_row  <= sw_value;
                        r_found     <= sw_found;
                        r_average   <= '0;
                        r_last      <= 1'b0;
                        r_sum       <= sum_next;
                        r_cnt       <= cnt_next;
                        if (r_sw_col == COL_W'(COLUMNS - 1)) begin
                            r_quo   <= sum_next;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_sw_col <= r_sw_col + COL_W'(1);
                            r_state  <= ST_RD;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= div_ge ? div_sub[CNT_W-1:0] : div_t[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], div_ge};
                    if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= ST_AVG;
                    end else begin
                        r_step <= r_step + DIV_CNT_W'(1);
                    end
                end
                ST_AVG: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_column    <= '0;
                        r_line_row  <= '0;
                        r_found     <= 1'b0;
                        r_average   <= r_quo[ROW_W-1:0];
                        r_last      <= 1'b1;
                        r_valid     <= '0;
                        r_sum       <= '0;
                        r_cnt       <= CNT_W'(1);
                        r_state     <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_column    = r_column;
    assign o_line_row  = r_line_row;
    assign o_found     = r_found;
    assign o_average   = r_average;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(COLUMNS)) && (r_row < ROW_W'(ROWS)))
        else $error("pixel position out of range");

    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_hit |-> (r_s1_act && (r_s1_col == $past(r_s1_col))))
        else $error("forwarding without a matching write");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != '0))
        else $error("average divisor is zero");

    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RD) || (r_state == ST_EMIT)) |-> !r_s1_act)
        else $error("column write during frame end sweep");

    a_last_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> ((r_column == '0) && !r_found && (r_line_row == '0)))
        else $error("average item carries column data");
`endif

endmodule

`default_nettype wire

// ===== test/tb_column_line_edge_finder.sv =====
`timescale 1ns / 1ps
// tb_column_line_edge_finder: self-checking bench for the column line edge finder
// depends on clef_pkg and column_line_edge_finder; whole frames are checked against a predictor or a typed answer

module tb_column_line_edge_finder;

    import clef_pkg::*;

    localparam int SETTLE_CYCLES = 4 * COLUMNS + 64;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int PLAN_ROWS     = 16;

    typedef enum logic [1:0] {PAT_SPLIT, PAT_FLOOR, PAT_RANDOM} t_pattern;
    typedef enum logic [1:0] {STYLE_LIGHT, STYLE_SPARSE, STYLE_HALF, STYLE_CUT} t_col_style;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] line_row;
        logic             found;
        logic [ROW_W-1:0] average;
        logic             last;
    } t_line_item;

    // one directed frame: optional threshold write, pixel pattern, optional typed answer
    typedef struct packed {
        logic             write_cfg;
        logic [PIX_W-1:0] threshold;
        t_pattern         pat;
        logic [6:0]       depth;
        logic [PIX_W-1:0] dark_pix;
        logic [PIX_W-1:0] light_pix;
        logic             with_start;
        logic [12:0]      junk;
        logic             typed;
        logic [ROW_W-1:0] line;
        logic             found;
        logic [ROW_W-1:0] avg;
    } t_frame_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [PIX_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic [PIX_W-1:0] i_pixel = '0;
    logic             i_frame_start = 1'b0;
    logic             i_out_ready = 1'b0;
    logic             o_cfg_ready;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [COL_W-1:0] o_column;
    logic [ROW_W-1:0] o_line_row;
    logic             o_found;
    logic [ROW_W-1:0] o_average;
    logic             o_last;

    column_line_edge_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_column      (o_column),
        .o_line_row    (o_line_row),
        .o_found       (o_found),
        .o_average     (o_average),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_frame_row frame_plan [PLAN_ROWS] = '{
        '{1'b0, 8'd128, PAT_SPLIT,  7'd80, 8'd127, 8'd128, 1'b1, 13'd0,    1'b1, 7'd75, 1'b1, 7'd73},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd0,  8'd127, 8'd128, 1'b1, 13'd0,    1'b1, 7'd0,  1'b0, 7'd0},
        '{1'b1, 8'd0,   PAT_SPLIT,  7'd80, 8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd0,  1'b0, 7'd0},
        '{1'b1, 8'd255, PAT_SPLIT,  7'd80, 8'd254, 8'd255, 1'b1, 13'd0,    1'b1, 7'd75, 1'b1, 7'd73},
        '{1'b0, 8'd255, PAT_SPLIT,  7'd0,  8'd254, 8'd255, 1'b0, 13'd0,    1'b1, 7'd0,  1'b0, 7'd0},
        '{1'b1, 8'd128, PAT_SPLIT,  7'd40, 8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd39, 1'b1, 7'd38},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd40, 8'd0,   8'd255, 1'b0, 13'd0,    1'b1, 7'd39, 1'b1, 7'd38},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd2,  8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd1,  1'b1, 7'd0},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd3,  8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd2,  1'b1, 7'd1},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd1,  8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd0,  1'b0, 7'd0},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd78, 8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd77, 1'b1, 7'd75},
        '{1'b0, 8'd128, PAT_SPLIT,  7'd79, 8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd75, 1'b1, 7'd73},
        '{1'b0, 8'd128, PAT_FLOOR,  7'd78, 8'd0,   8'd255, 1'b1, 13'd0,    1'b1, 7'd75, 1'b1, 7'd73},
        '{1'b0, 8'd128, PAT_FLOOR,  7'd3,  8'd100, 8'd200, 1'b1, 13'd333,  1'b1, 7'd75, 1'b1, 7'd73},
        '{1'b1, 8'd77,  PAT_RANDOM, 7'd0,  8'd0,   8'd0,   1'b0, 13'd0,    1'b0, 7'd0,  1'b0, 7'd0},
        '{1'b0, 8'd77,  PAT_RANDOM, 7'd0,  8'd0,   8'd0,   1'b1, 13'd4799, 1'b0, 7'd0,  1'b0, 7'd0}
    };

    // predictor state
    logic [PIX_W-1:0]  thr_model;
    logic [HIST_W-1:0] dark_hist_m [COLUMNS];
    logic [ROW_W-1:0]  line_m [COLUMNS];
    logic              found_m [COLUMNS];
    int unsigned       row_m;
    int unsigned       col_m;

    // typed answer for the frame in flight, used instead of the predictor when set
    logic              use_typed = 1'b0;
    logic [ROW_W-1:0]  typed_line;
    logic              typed_found;
    logic [ROW_W-1:0]  typed_avg;

    t_line_item        pending_lines [$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;

    t_col_style        col_style [COLUMNS];
    int unsigned       col_cut [COLUMNS];

    function automatic void restart_frame_model();
        for (int k = 0; k < COLUMNS; k++) begin
            dark_hist_m[k] = '0;
            found_m[k] = 1'b0;
        end
        row_m = 0;
        col_m = 0;
    endfunction

    // advance the predictor by one pixel; queues a frame's lines when the frame closes
    function automatic void track_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned       c;
        int unsigned       r;
        int unsigned       sum;
        int unsigned       cnt;
        logic              dark;
        logic [HIST_W-1:0] h;
        t_line_item        item;
        if (fs)
            restart_frame_model();
        c = (col_m >= COLUMNS) ? 0 : col_m;
        r = row_m;
        dark = pix < thr_model;
        h = dark_hist_m[c];
        if (r >= 3) begin
            if (dark && h[0]) begin
                line_m[c] = ROW_W'(NEAR_EDGE_VALUE);
                found_m[c] = 1'b1;
            end else if (!dark && !h[0] && h[1] && h[2]) begin
                line_m[c] = ROW_W'(r - 2);
                found_m[c] = 1'b1;
            end
        end
        dark_hist_m[c] = {h[1:0], dark};
        c++;
        if (c >= COLUMNS) begin
            c = 0;
            r++;
        end
        col_m = c;
        row_m = r;
        if (r >= ROWS) begin
            sum = 0;
            cnt = 1;
            for (int k = 0; k < COLUMNS; k++) begin
                item = '0;
                item.column = COL_W'(k);
                item.found = found_m[k];
                item.line_row = found_m[k] ? line_m[k] : '0;
                if (found_m[k]) begin
                    sum = (sum + line_m[k]) % (1 << SUM_W);
                    cnt = (cnt + 1) % (1 << CNT_W);
                end
                if (use_typed) begin
                    item.line_row = typed_line;
                    item.found = typed_found;
                end
                pending_lines.push_back(item);
            end
            item = '0;
            item.last = 1'b1;
            item.average = use_typed ? typed_avg : ROW_W'((cnt != 0) ? sum / cnt : 0);
            pending_lines.push_back(item);
            restart_frame_model();
        end
    endfunction

    function automatic void note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    function automatic void check_line();
        t_line_item got;
        t_line_item want;
        got = {o_column, o_line_row, o_found, o_average, o_last};
        if (pending_lines.size() == 0) begin
            note_failure($sformatf("unexpected result column %0d line %0d last %0d",
                                   o_column, o_line_row, o_last));
            return;
        end
        want = pending_lines.pop_front();
        if (got.column !== want.column || got.line_row !== want.line_row ||
                got.found !== want.found || got.average !== want.average ||
                got.last !== want.last)
            note_failure($sformatf({"exp/got column %0d/%0d line %0d/%0d found %0d/%0d ",
                                    "average %0d/%0d last %0d/%0d"},
                                   want.column, got.column, want.line_row, got.line_row,
                                   want.found, got.found, want.average, got.average,
                                   want.last, got.last));
    endfunction

    // result side: check on every accepted result, then pick the next ready level
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_line();
            i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one pixel request; valid stays up afterwards so back-to-back pixels need no re-raise
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
        track_pixel(pix, fs);
    endtask

    task automatic write_threshold(input logic [PIX_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_model = value;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] light_value();
        return PIX_W'($urandom_range(255, thr_model));
    endfunction

    function automatic logic [PIX_W-1:0] dark_value();
        if (thr_model == 0)
            return light_value();
        return PIX_W'($urandom_range(thr_model - 1, 0));
    endfunction

    function automatic logic random_dark(input int c, input int r);
        case (col_style[c])
            STYLE_LIGHT:  return 1'b0;
            STYLE_SPARSE: return $urandom_range(7, 0) == 0;
            STYLE_HALF:   return $urandom_range(1, 0) == 1;
            default:      return r < col_cut[c];
        endcase
    endfunction

    // optional dropped partial frame, then one whole frame of the chosen pattern
    task automatic send_frame(input t_pattern pat, input int depth,
                              input logic [PIX_W-1:0] dk, input logic [PIX_W-1:0] lt,
                              input logic with_start, input int junk);
        logic             dark;
        logic [PIX_W-1:0] pix;
        for (int j = 0; j < junk; j++)
            push_pixel(PIX_W'($urandom_range(255, 0)), j == 0 || $urandom_range(63, 0) == 0);
        for (int c = 0; c < COLUMNS; c++) begin
            col_style[c] = t_col_style'($urandom_range(3, 0));
            col_cut[c] = $urandom_range(ROWS, 0);
        end
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                case (pat)
                    PAT_SPLIT: dark = r < depth;
                    PAT_FLOOR: dark = r >= depth;
                    default:   dark = random_dark(c, r);
                endcase
                if (pat != PAT_RANDOM)
                    pix = dark ? dk : lt;
                else if ($urandom_range(31, 0) == 0)
                    pix = PIX_W'($urandom_range(255, 0));
                else
                    pix = dark ? dark_value() : light_value();
                push_pixel(pix, r == 0 && c == 0 && (with_start || junk != 0));
            end
        end
    endtask

    initial begin
        logic with_start;
        int   junk;
        thr_model = THRESHOLD_RESET;
        for (int k = 0; k < COLUMNS; k++)
            line_m[k] = '0;
        restart_frame_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_plan[i]) begin
            if (frame_plan[i].write_cfg)
                write_threshold(frame_plan[i].threshold);
            use_typed = frame_plan[i].typed;
            typed_line = frame_plan[i].line;
            typed_found = frame_plan[i].found;
            typed_avg = frame_plan[i].avg;
            send_frame(frame_plan[i].pat, frame_plan[i].depth, frame_plan[i].dark_pix,
                       frame_plan[i].light_pix, frame_plan[i].with_start, frame_plan[i].junk);
            settle();
        end
        use_typed = 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_threshold(PIX_W'($urandom_range(200, 40)));
                end
                1: begin
                    send_idle_pct = 74;
                    recv_stall_pct = 0;
                    write_threshold(PIX_W'(1));
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 74;
                    write_threshold(PIX_W'($urandom_range(255, 0)));
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                    write_threshold(PIX_W'(255));
                end
            endcase
            // frames run back to back so the next frame waits on the result sweep
            for (int f = 0; f < 2; f++) begin
                with_start = $urandom_range(1, 0);
                junk = ($urandom_range(2, 0) == 0) ? $urandom_range(ROWS * COLUMNS - 1, 1) : 0;
                send_frame(PAT_RANDOM, 0, '0, '0, with_start, junk);
            end
            settle();
        end

        if (mismatch_count == 0 && pending_lines.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/clef_pkg.sv
hdl/column_line_edge_finder.sv
test/tb_column_line_edge_finder.sv
